[src/nopi_pkg.sv]
// ----------------------------------------------------------------------------
// nopi_pkg
// Shared types, constants and arithmetic helpers for the pose integrator.
// ----------------------------------------------------------------------------
package nopi_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int MUL_BITS         = 40;
    localparam int PROD_W           = 80;
    localparam int CNT_W            = 6;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 16;
    localparam int CRD_W            = 36;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_RATIO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RATIO  = CFG_IDX_W'(1);

    localparam logic signed [PROD_W-1:0] PI_Q      = 80'sd843314857;
    localparam logic signed [PROD_W-1:0] TWO_PI_Q  = 80'sd1686629713;
    localparam logic signed [PROD_W-1:0] HALF_PI_Q = 80'sd421657428;
    localparam logic signed [PROD_W-1:0] S32_MAX   = 80'sd2147483647;
    localparam logic signed [PROD_W-1:0] S32_MIN   = -80'sd2147483648;
    localparam logic signed [PROD_W-1:0] D_MAX     = 80'sd4294967295;
    localparam logic [31:0]              INV_GAIN_Q32 = 32'h9B74EDA8;
    localparam logic signed [CRD_W-1:0]  INV_GAIN_Q30 = 36'sh026DD3B6A;
    localparam logic signed [PROD_W-1:0] ONE_Q28   = 80'sd268435456;

    typedef enum logic [2:0] {
        OP_GAIN, OP_SPD, OP_TURN, OP_HALF, OP_DIST, OP_DX, OP_DY
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_VEC, S_MINIT, S_MUL, S_WB, S_ROT, S_OUT
    } t_state;

    typedef struct packed {
        logic             capture;
        logic             cordic_step;
        logic             rot_mode;
        logic             mul_init;
        logic             mul_step;
        logic             mul_wb;
        t_op              op;
        logic [CNT_W-1:0] iter;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

    function automatic logic signed [32:0] atan_q28(input logic [4:0] i);
        logic signed [32:0] r;
        case (i)
            5'd0:    r = 33'sd210828714;
            5'd1:    r = 33'sd124459457;
            5'd2:    r = 33'sd65760959;
            5'd3:    r = 33'sd33381290;
            5'd4:    r = 33'sd16755422;
            5'd5:    r = 33'sd8385879;
            5'd6:    r = 33'sd4193963;
            5'd7:    r = 33'sd2097109;
            5'd8:    r = 33'sd1048571;
            5'd9:    r = 33'sd524287;
            5'd29, 5'd30, 5'd31: r = 33'sd0;
            default: r = 33'sd1 <<< (5'd28 - i);
        endcase
        return r;
    endfunction

    // round to nearest, ties up, then arithmetic shift
    function automatic logic signed [PROD_W-1:0] rnd_shr(
        input logic signed [PROD_W-1:0] v, input int s);
        logic signed [PROD_W-1:0] b;
        b = 80'sd1 <<< (s - 1);
        return (v + b) >>> s;
    endfunction

    function automatic logic signed [PROD_W-1:0] sat(
        input logic signed [PROD_W-1:0] v,
        input logic signed [PROD_W-1:0] lo,
        input logic signed [PROD_W-1:0] hi);
        logic signed [PROD_W-1:0] r;
        r = (v < lo) ? lo : ((v > hi) ? hi : v);
        return r;
    endfunction

endpackage

[src/nopi_ctrl.sv]
// ----------------------------------------------------------------------------
// nopi_ctrl
// Sequencer: cordic passes and the chain of shared multiplications.
// ----------------------------------------------------------------------------
module nopi_ctrl #(
    parameter int CORDIC_STEPS = nopi_pkg::CORDIC_STEPS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_out_ready,
    input  nopi_pkg::t_stat i_stat,
    output nopi_pkg::t_cmd  o_cmd
);

    nopi_pkg::t_state r_state, n_state;
    nopi_pkg::t_op    r_op, n_op;
    logic [nopi_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic w_crd_last, w_mul_last;

    assign w_crd_last = (r_cnt == nopi_pkg::CNT_W'(CORDIC_STEPS - 1));
    assign w_mul_last = (r_cnt == nopi_pkg::CNT_W'(nopi_pkg::MUL_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nopi_pkg::S_IDLE;
            r_op    <= nopi_pkg::OP_GAIN;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt + nopi_pkg::CNT_W'(1);
        unique case (r_state)
            nopi_pkg::S_IDLE: begin
                n_cnt = '0;
                if (i_valid) n_state = nopi_pkg::S_VEC;
            end
            nopi_pkg::S_VEC: begin
                if (w_crd_last) begin
                    n_state = nopi_pkg::S_MINIT;
                    n_op    = nopi_pkg::OP_GAIN;
                end
            end
            nopi_pkg::S_MINIT: begin
                n_cnt   = '0;
                n_state = nopi_pkg::S_MUL;
            end
            nopi_pkg::S_MUL: begin
                if (w_mul_last) n_state = nopi_pkg::S_WB;
            end
            nopi_pkg::S_WB: begin
                n_cnt   = '0;
                n_state = nopi_pkg::S_MINIT;
                unique case (r_op)
                    nopi_pkg::OP_GAIN: n_op = nopi_pkg::OP_SPD;
                    nopi_pkg::OP_SPD:  n_op = nopi_pkg::OP_TURN;
                    nopi_pkg::OP_TURN: n_op = nopi_pkg::OP_HALF;
                    nopi_pkg::OP_HALF: n_state = nopi_pkg::S_ROT;
                    nopi_pkg::OP_DIST: n_op = nopi_pkg::OP_DX;
                    nopi_pkg::OP_DX:   n_op = nopi_pkg::OP_DY;
                    nopi_pkg::OP_DY:   n_state = nopi_pkg::S_OUT;
                    default:           n_state = nopi_pkg::S_IDLE;
                endcase
            end
            nopi_pkg::S_ROT: begin
                if (w_crd_last) begin
                    n_state = nopi_pkg::S_MINIT;
                    n_op    = nopi_pkg::OP_DIST;
                end
            end
            nopi_pkg::S_OUT: begin
                if (!i_stat.out_full || i_out_ready) n_state = nopi_pkg::S_IDLE;
            end
            default: n_state = nopi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.op          = r_op;
        o_cmd.iter        = r_cnt;
        o_ready           = 1'b0;
        unique case (r_state)
            nopi_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            nopi_pkg::S_VEC:   o_cmd.cordic_step = 1'b1;
            nopi_pkg::S_MINIT: o_cmd.mul_init    = 1'b1;
            nopi_pkg::S_MUL:   o_cmd.mul_step    = 1'b1;
            nopi_pkg::S_WB:    o_cmd.mul_wb      = 1'b1;
            nopi_pkg::S_ROT: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.rot_mode    = 1'b1;
            end
            nopi_pkg::S_OUT: o_cmd.out_load = !i_stat.out_full || i_out_ready;
            default: ;
        endcase
    end

endmodule

[src/nopi_dpath.sv]
// ----------------------------------------------------------------------------
// nopi_dpath
// Datapath: shared cordic unit, bit-serial multiplier, pose state, outputs.
// ----------------------------------------------------------------------------
module nopi_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nopi_pkg::t_cmd                     i_cmd,
    output nopi_pkg::t_stat                    o_stat,
    input  logic [nopi_pkg::CFG_DATA_W-1:0]    i_speed_ratio,
    input  logic [nopi_pkg::CFG_DATA_W-1:0]    i_turn_ratio,
    input  logic        [31:0]                 i_stamp,
    input  logic signed [31:0]                 i_vel_x,
    input  logic signed [31:0]                 i_vel_y,
    input  logic signed [31:0]                 i_yaw_rate,
    input  logic signed [15:0]                 i_noise_speed,
    input  logic signed [15:0]                 i_noise_turn,
    input  logic                               i_ready,
    output logic                               o_valid,
    output logic signed [31:0]                 o_pos_x,
    output logic signed [31:0]                 o_pos_y,
    output logic signed [30:0]                 o_heading,
    output logic signed [31:0]                 o_noisy_speed,
    output logic signed [31:0]                 o_noisy_turn
);

    localparam int PW = nopi_pkg::PROD_W;
    localparam int CW = nopi_pkg::CRD_W;

    // item and pose state
    logic        [31:0] r_prev, r_dt;
    logic signed [31:0] r_yaw, r_spd, r_turn, r_pos_x, r_pos_y, r_head;
    logic signed [33:0] r_fs, r_ft, r_dist;
    logic signed [32:0] r_th, r_half;
    logic               r_neg;
    // cordic
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [32:0]   r_cz;
    // multiplier
    logic signed [PW-1:0] r_mul_a, r_mul_p;
    logic        [nopi_pkg::MUL_BITS-1:0] r_mul_b;
    logic               r_o_valid;

    logic signed [CW-1:0] w_xs, w_ys, w_ax, w_ay;
    logic signed [32:0]   w_at;
    logic                 w_dir;
    logic signed [32:0]   w_fs_m, w_ft_m;
    logic signed [PW-1:0] w_opa, w_opb, w_h, w_th, w_th2, w_z;
    logic signed [CW-1:0] w_cos, w_sin;

    assign w_xs = r_cx >>> i_cmd.iter[4:0];
    assign w_ys = r_cy >>> i_cmd.iter[4:0];
    assign w_at = nopi_pkg::atan_q28(i_cmd.iter[4:0]);
    // rotate toward the x axis when vectoring, drive the angle to zero otherwise
    assign w_dir = i_cmd.rot_mode ? !r_cz[32] : r_cy[CW-1];

    assign w_ax = i_vel_x[31] ? -CW'(i_vel_x) : CW'(i_vel_x);
    assign w_ay = i_vel_y[31] ? -CW'(i_vel_y) : CW'(i_vel_y);
    assign w_fs_m = i_noise_speed * $signed({1'b0, i_speed_ratio});
    assign w_ft_m = i_noise_turn * $signed({1'b0, i_turn_ratio});

    assign w_cos = r_neg ? -r_cx : r_cx;
    assign w_sin = r_neg ? -r_cy : r_cy;

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (i_cmd.op)
            nopi_pkg::OP_GAIN: begin
                w_opa = PW'(r_cx);
                w_opb = PW'(nopi_pkg::INV_GAIN_Q32);
            end
            nopi_pkg::OP_SPD: begin
                w_opa = PW'(r_spd);
                w_opb = PW'(r_fs);
            end
            nopi_pkg::OP_TURN: begin
                w_opa = PW'(r_yaw);
                w_opb = PW'(r_ft);
            end
            nopi_pkg::OP_HALF: begin
                w_opa = PW'(r_turn);
                w_opb = PW'(r_dt);
            end
            nopi_pkg::OP_DIST: begin
                w_opa = PW'(r_spd);
                w_opb = PW'(r_dt);
            end
            nopi_pkg::OP_DX: begin
                w_opa = PW'(r_dist);
                w_opb = PW'(w_cos);
            end
            nopi_pkg::OP_DY: begin
                w_opa = PW'(r_dist);
                w_opb = PW'(w_sin);
            end
            default: ;
        endcase
    end

    // half step, midpoint heading with quadrant fold, and final wrap
    always_comb begin
        w_h   = nopi_pkg::sat(nopi_pkg::rnd_shr(r_mul_p, 5),
                              -nopi_pkg::HALF_PI_Q, nopi_pkg::HALF_PI_Q);
        w_th  = PW'(r_head) + w_h;
        w_z   = w_th;
        if (w_th > nopi_pkg::HALF_PI_Q)       w_z = w_th - nopi_pkg::PI_Q;
        else if (w_th < -nopi_pkg::HALF_PI_Q) w_z = w_th + nopi_pkg::PI_Q;
        w_th2 = PW'(r_th) + PW'(r_half);
        if (w_th2 > nopi_pkg::PI_Q)  w_th2 = w_th2 - nopi_pkg::TWO_PI_Q;
        if (w_th2 < -nopi_pkg::PI_Q) w_th2 = w_th2 + nopi_pkg::TWO_PI_Q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_head    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_prev <= i_stamp;
                r_dt   <= i_stamp - r_prev;
                r_yaw  <= i_yaw_rate;
                r_cx   <= w_ax;
                r_cy   <= w_ay;
                r_fs   <= 34'(nopi_pkg::ONE_Q28) + 34'(w_fs_m);
                r_ft   <= 34'(nopi_pkg::ONE_Q28) + 34'(w_ft_m);
            end
            if (i_cmd.cordic_step) begin
                if (w_dir) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - w_at;
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + w_at;
                end
            end
            if (i_cmd.mul_init) begin
                r_mul_a <= w_opa;
                r_mul_b <= w_opb[nopi_pkg::MUL_BITS-1:0];
                r_mul_p <= '0;
            end
            if (i_cmd.mul_step) begin
                // top multiplier bit carries negative weight
                if (r_mul_b[0]) begin
                    if (i_cmd.iter == nopi_pkg::CNT_W'(nopi_pkg::MUL_BITS - 1))
                        r_mul_p <= r_mul_p - r_mul_a;
                    else
                        r_mul_p <= r_mul_p + r_mul_a;
                end
                r_mul_a <= r_mul_a <<< 1;
                r_mul_b <= r_mul_b >> 1;
            end
            if (i_cmd.mul_wb) begin
                case (i_cmd.op)
                    nopi_pkg::OP_GAIN:
                        r_spd <= 32'(nopi_pkg::sat(nopi_pkg::rnd_shr(r_mul_p, 32),
                                                   '0, nopi_pkg::S32_MAX));
                    nopi_pkg::OP_SPD:
                        r_spd <= 32'(nopi_pkg::sat(nopi_pkg::rnd_shr(r_mul_p, 28),
                                                   nopi_pkg::S32_MIN, nopi_pkg::S32_MAX));
                    nopi_pkg::OP_TURN:
                        r_turn <= 32'(nopi_pkg::sat(nopi_pkg::rnd_shr(r_mul_p, 28),
                                                    nopi_pkg::S32_MIN, nopi_pkg::S32_MAX));
                    nopi_pkg::OP_HALF: begin
                        r_half <= 33'(w_h);
                        r_th   <= 33'(w_th);
                        r_neg  <= (w_z != w_th);
                        r_cz   <= 33'(w_z);
                        r_cx   <= nopi_pkg::INV_GAIN_Q30;
                        r_cy   <= '0;
                    end
                    nopi_pkg::OP_DIST:
                        r_dist <= 34'(nopi_pkg::sat(nopi_pkg::rnd_shr(r_mul_p, 16),
                                                    -nopi_pkg::D_MAX, nopi_pkg::D_MAX));
                    nopi_pkg::OP_DX:
                        r_pos_x <= 32'(nopi_pkg::sat(
                            PW'(r_pos_x) + nopi_pkg::rnd_shr(r_mul_p, 30),
                            nopi_pkg::S32_MIN, nopi_pkg::S32_MAX));
                    nopi_pkg::OP_DY: begin
                        r_pos_y <= 32'(nopi_pkg::sat(
                            PW'(r_pos_y) + nopi_pkg::rnd_shr(r_mul_p, 30),
                            nopi_pkg::S32_MIN, nopi_pkg::S32_MAX));
                        r_head  <= 32'(w_th2);
                    end
                    default: ;
                endcase
            end
            if (i_cmd.out_load)  r_o_valid <= 1'b1;
            else if (i_ready)    r_o_valid <= 1'b0;
        end
    end

    // result register, filled only once the previous beat has gone
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pos_x       <= r_pos_x;
            o_pos_y       <= r_pos_y;
            o_heading     <= r_head[30:0];
            o_noisy_speed <= r_spd;
            o_noisy_turn  <= r_turn;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_stat.out_full = r_o_valid;

endmodule

[src/noisy_odometry_pose_integrator.sv]
// ----------------------------------------------------------------------------
// noisy_odometry_pose_integrator
// Midpoint odometry with noisy speed and yaw rate, fixed point.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | i_valid / o_ready          | stamp, velocity, yaw rate, noise
//  output   | o_valid / i_ready          | pose, heading, noisy speed / turn
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one item runs through two cordic passes of one step a cycle and seven
//  products on a shared bit-serial multiplier of 40 steps each, between
//  the accept state and the output state.
//  reset is synchronous and clears pose, previous stamp and ratio registers.
//  a finished result waits in the output register; the next item is taken
//  meanwhile and only its output load stalls on a full output register.
// ----------------------------------------------------------------------------
module noisy_odometry_pose_integrator #(
    parameter int CORDIC_STEPS = nopi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic        [31:0]                  i_stamp,
    input  logic signed [31:0]                  i_vel_x,
    input  logic signed [31:0]                  i_vel_y,
    input  logic signed [31:0]                  i_yaw_rate,
    input  logic signed [15:0]                  i_noise_speed,
    input  logic signed [15:0]                  i_noise_turn,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [31:0]                  o_pos_x,
    output logic signed [31:0]                  o_pos_y,
    output logic signed [30:0]                  o_heading,
    output logic signed [31:0]                  o_noisy_speed,
    output logic signed [31:0]                  o_noisy_turn,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nopi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nopi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [nopi_pkg::CFG_DATA_W-1:0] r_speed_ratio, r_turn_ratio;
    nopi_pkg::t_cmd  w_cmd;
    nopi_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_ratio <= '0;
            r_turn_ratio  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nopi_pkg::REG_SPEED_RATIO: r_speed_ratio <= i_cfg_data;
                nopi_pkg::REG_TURN_RATIO:  r_turn_ratio  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    nopi_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    nopi_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_speed_ratio (r_speed_ratio),
        .i_turn_ratio  (r_turn_ratio),
        .i_stamp       (i_stamp),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_yaw_rate    (i_yaw_rate),
        .i_noise_speed (i_noise_speed),
        .i_noise_turn  (i_noise_turn),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_heading     (o_heading),
        .o_noisy_speed (o_noisy_speed),
        .o_noisy_turn  (o_noisy_turn)
    );

endmodule

[src/nopi_chk.sv]
// ----------------------------------------------------------------------------
// nopi_chk
// Port-level checks for the pose integrator, bound to the top level.
// ----------------------------------------------------------------------------
module nopi_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic signed [30:0]              o_heading,
    input logic signed [31:0]              o_pos_x
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pos_x) && $stable(o_heading))
        else $error("result beat changed while stalled");

    // one item at a time: no second input straight after an accepted one
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken on back-to-back cycles");

    a_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading <= 31'sd843314857) && (o_heading >= -31'sd843314857))
        else $error("heading outside plus or minus pi");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind noisy_odometry_pose_integrator nopi_chk u_nopi_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_heading (o_heading),
    .o_pos_x   (o_pos_x)
);

[tb/pose_checker.sv]
// ----------------------------------------------------------------------------
// pose_checker
// Watches the sample, pose and register channels of the pose integrator,
// predicts each pose from its own fixed-point model and compares every field.
// ----------------------------------------------------------------------------
module pose_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_in_ready,
    input  logic        [31:0]              i_stamp,
    input  logic signed [31:0]              i_vel_x,
    input  logic signed [31:0]              i_vel_y,
    input  logic signed [31:0]              i_yaw_rate,
    input  logic signed [15:0]              i_noise_speed,
    input  logic signed [15:0]              i_noise_turn,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic signed [31:0]              i_pos_x,
    input  logic signed [31:0]              i_pos_y,
    input  logic signed [30:0]              i_heading,
    input  logic signed [31:0]              i_noisy_speed,
    input  logic signed [31:0]              i_noisy_turn,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [nopi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nopi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = nopi_pkg::CORDIC_STEPS_DEF;
    localparam longint PI_L   = longint'(nopi_pkg::PI_Q);
    localparam longint TWO_PI = longint'(nopi_pkg::TWO_PI_Q);
    localparam longint HALF_PI = longint'(nopi_pkg::HALF_PI_Q);
    localparam longint MAX32  = longint'(nopi_pkg::S32_MAX);
    localparam longint MIN32  = longint'(nopi_pkg::S32_MIN);
    localparam longint DMAX   = longint'(nopi_pkg::D_MAX);

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [30:0] heading;
        logic [31:0] speed;
        logic [31:0] turn;
    } t_pose;

    t_pose  pose_expect_q[$];
    longint speed_ratio, turn_ratio;
    longint x_pos, y_pos, yaw_acc;
    logic [31:0] last_stamp;

    function automatic longint shr_round(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint arctan_step(int i);
        longint head[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                             8385879, 4193963, 2097109, 1048571, 524287};
        if (i < 10) return head[i];
        if (i <= 28) return 64'sd1 <<< (28 - i);
        return 0;
    endfunction

    function automatic longint planar_speed(longint a, longint b);
        longint x, y, xs, ys;
        longint unsigned p;
        x = a < 0 ? -a : a;
        y = b < 0 ? -b : b;
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs;
            end else begin
                x -= ys; y += xs;
            end
        end
        p = longint'(x) * {32'd0, nopi_pkg::INV_GAIN_Q32} + 64'h80000000;
        return clamp(longint'(p >> 32), 0, MAX32);
    endfunction

    task automatic heading_cos_sin(input longint ang, output longint c, output longint s);
        longint x, y, z, xs, ys;
        bit flip;
        x = longint'(nopi_pkg::INV_GAIN_Q30);
        y = 0;
        z = ang;
        flip = 0;
        if (z > HALF_PI) begin
            z -= PI_L; flip = 1;
        end else if (z < -HALF_PI) begin
            z += PI_L; flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= arctan_step(i);
            end else begin
                x += ys; y -= xs; z += arctan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint apply_noise(longint v, longint noise, longint ratio);
        longint f;
        f = (64'sd1 <<< 28) + noise * ratio;
        return clamp(shr_round(v * f, 28), MIN32, MAX32);
    endfunction

    task automatic predict_pose();
        longint dt, v, wn, h, th, c, s, d;
        t_pose p;
        dt = longint'({32'd0, i_stamp - last_stamp});
        last_stamp = i_stamp;
        v = apply_noise(planar_speed(i_vel_x, i_vel_y), i_noise_speed, speed_ratio);
        wn = apply_noise(i_yaw_rate, i_noise_turn, turn_ratio);
        h = clamp(shr_round(wn * dt, 5), -HALF_PI, HALF_PI);
        th = yaw_acc + h;
        heading_cos_sin(th, c, s);
        d = clamp(shr_round(v * dt, 16), -DMAX, DMAX);
        x_pos = clamp(x_pos + shr_round(d * c, 30), MIN32, MAX32);
        y_pos = clamp(y_pos + shr_round(d * s, 30), MIN32, MAX32);
        th += h;
        if (th > PI_L) th -= TWO_PI;
        if (th < -PI_L) th += TWO_PI;
        yaw_acc = th;
        p.pos_x = x_pos[31:0];
        p.pos_y = y_pos[31:0];
        p.heading = yaw_acc[30:0];
        p.speed = v[31:0];
        p.turn = wn[31:0];
        pose_expect_q.push_back(p);
    endtask

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial o_errors = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_pose p;
        if (!i_rst_n) begin
            speed_ratio = 0;
            turn_ratio = 0;
            x_pos = 0;
            y_pos = 0;
            yaw_acc = 0;
            last_stamp = '0;
            pose_expect_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pose_expect_q.size() == 0) begin
                    $display("%0t: pose beat with nothing expected", $time);
                    o_errors++;
                end else begin
                    p = pose_expect_q.pop_front();
                    compare_field("pos_x", p.pos_x, i_pos_x);
                    compare_field("pos_y", p.pos_y, i_pos_y);
                    compare_field("heading", {1'b0, p.heading}, {1'b0, i_heading});
                    compare_field("noisy_speed", p.speed, i_noisy_speed);
                    compare_field("noisy_turn", p.turn, i_noisy_turn);
                end
            end
            if (i_valid && i_in_ready) predict_pose();
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == nopi_pkg::REG_SPEED_RATIO)
                    speed_ratio = longint'({48'd0, i_cfg_data});
                else if (i_cfg_index == nopi_pkg::REG_TURN_RATIO)
                    turn_ratio = longint'({48'd0, i_cfg_data});
            end
        end
        o_pending = pose_expect_q.size();
    end
endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives samples and ratio settings into the pose integrator with bursty
// traffic and a stalling pose sink; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic [31:0] i_stamp;
    logic signed [31:0] i_vel_x, i_vel_y, i_yaw_rate;
    logic signed [15:0] i_noise_speed, i_noise_turn;
    logic signed [31:0] o_pos_x, o_pos_y, o_noisy_speed, o_noisy_turn;
    logic signed [30:0] o_heading;
    logic i_cfg_valid, o_cfg_ready;
    logic [nopi_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [nopi_pkg::CFG_DATA_W-1:0] i_cfg_data;
    int errors, pending;
    int burst_left;
    logic [31:0] stamp_now;
    int sink_mode;

    noisy_odometry_pose_integrator DUT (.*);

    pose_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_stamp, .i_vel_x,
        .i_vel_y, .i_yaw_rate, .i_noise_speed, .i_noise_turn,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_pos_x(o_pos_x),
        .i_pos_y(o_pos_y), .i_heading(o_heading), .i_noisy_speed(o_noisy_speed),
        .i_noisy_turn(o_noisy_turn), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("testbench NOT OK");
        $finish;
    end

    // sink stalls: always ready, sparse, or coin flip, changing now and then
    initial sink_mode = 0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 599) == 0) sink_mode <= $urandom_range(0, 2);
        case (sink_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= $urandom_range(0, 1);
        endcase
    end

    task automatic write_ratio(logic [nopi_pkg::CFG_IDX_W-1:0] idx,
                               logic [nopi_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every pending pose has been taken
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [31:0] dt, logic [31:0] vx, logic [31:0] vy,
                               logic [31:0] w, logic [15:0] ns, logic [15:0] nt);
        stamp_now = stamp_now + dt;
        i_valid       <= 1'b1;
        i_stamp       <= stamp_now;
        i_vel_x       <= vx;
        i_vel_y       <= vy;
        i_yaw_rate    <= w;
        i_noise_speed <= ns;
        i_noise_turn  <= nt;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 6);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 400)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic random_samples(int n);
        logic [31:0] dt, vx, vy, w;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                dt = $urandom; vx = $urandom; vy = $urandom; w = $urandom;
            end else begin
                dt = $urandom_range(0, 32'h1_0000);
                vx = $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
                vy = $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
                w  = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
            end
            send_sample(dt, vx, vy, w, 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_stamp = '0;
        i_vel_x = '0;
        i_vel_y = '0;
        i_yaw_rate = '0;
        i_noise_speed = '0;
        i_noise_turn = '0;
        burst_left = 0;
        stamp_now = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // noise-free: first stamp, extremes, large turn, long step, overflow
        send_sample(32'h0000_8000, 32'sh0001_0000, 0, 0, 0, 0);
        send_sample(32'h0000_4000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    16'sh8000, 16'sh8000);
        send_sample(32'h0001_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                    16'sh7fff, 16'sh7fff);
        send_sample(32'hffff_ffff, 32'sh7fff_ffff, 0, 32'sh0040_0000, 0, 0);
        send_sample(32'h8000_0000, 0, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
        for (int k = 0; k < 4; k++)
            send_sample(32'hf000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0);
        send_sample(0, 32'sh0003_0000, 32'shfffc_0000, 32'sh0001_0000, 0, 0);
        drain();

        write_ratio(nopi_pkg::REG_SPEED_RATIO, 16'hffff);
        write_ratio(nopi_pkg::REG_TURN_RATIO, 16'hffff);
        write_ratio(nopi_pkg::CFG_IDX_W'(7), 16'h1234);
        send_sample(32'h0000_1000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0000_8000,
                    16'sh7fff, 16'sh8000);
        send_sample(32'h0000_1000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                    16'sh7fff, 16'sh7fff);
        send_sample(32'h0000_1000, 32'sh8000_0000, 0, 32'sh8000_0000,
                    16'sh8000, 16'sh7fff);
        random_samples(250);
        drain();

        write_ratio(nopi_pkg::REG_SPEED_RATIO, 16'($urandom));
        write_ratio(nopi_pkg::REG_TURN_RATIO, 16'($urandom));
        random_samples(260);
        drain();

        write_ratio(nopi_pkg::REG_SPEED_RATIO, 16'h0000);
        write_ratio(nopi_pkg::REG_TURN_RATIO, 16'h1000);
        random_samples(260);
        drain();

        write_ratio(nopi_pkg::REG_SPEED_RATIO, 16'h0800);
        write_ratio(nopi_pkg::REG_TURN_RATIO, 16'h0000);
        write_ratio(nopi_pkg::CFG_IDX_W'(15), 16'hffff);
        random_samples(260);
        drain();
        repeat (400) @(posedge i_clk);

        if (errors == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end
endmodule

[noisy_odometry_pose_integrator.f]
src/nopi_pkg.sv
src/nopi_ctrl.sv
src/nopi_dpath.sv
src/noisy_odometry_pose_integrator.sv
src/nopi_chk.sv
tb/pose_checker.sv
tb/testbench.sv
